// File: design/pcxy_pkg.sv
// Shared types, constants and the sub-block table of the Peano index-to-point mapper.
package pcxy_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_LEVELS   = 2'd0;
    localparam logic [1:0] CFG_ORIENT_A = 2'd1;
    localparam logic [1:0] CFG_ORIENT_B = 2'd2;

    localparam int IDX_W  = 16;
    localparam int LV_W   = 4;   // holds a level count up to fifteen
    localparam int CFG_W  = 3;
    localparam int COORD_W = 8;
    localparam int QDEPTH = 2;

    localparam logic [31:0] POW9 [0:8] = '{
        32'd1, 32'd9, 32'd81, 32'd729, 32'd6561, 32'd59049,
        32'd531441, 32'd4782969, 32'd43046721
    };
    localparam logic [31:0] POW3 [0:8] = '{
        32'd1, 32'd3, 32'd9, 32'd27, 32'd81, 32'd243, 32'd729, 32'd2187, 32'd6561
    };

    // One classified item on its way to the back end
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [LV_W-1:0]  lv;
        logic             a;
        logic             b;
        logic             oor;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    // Offset and next orientation for one level
    typedef struct packed {
        logic [1:0] dx;
        logic [1:0] dy;
        logic       a;
        logic       b;
    } t_sub;

    function automatic t_sub subblock(input logic [3:0] digit, input logic a, input logic b);
        t_sub s;
        logic [1:0] ea;
        logic [1:0] eb;
        ea = {1'b0, a};
        eb = {1'b0, b};
        s.a = a;
        s.b = b;
        unique case (digit)
            4'd0: begin
                s.dx = ea << 1;
                s.dy = ea << 1;
            end
            4'd1: begin
                s.dx = ea + eb;
                s.dy = ea - eb + 2'd1;
                s.a  = ~a;
                s.b  = ~b;
            end
            4'd2: begin
                s.dx = eb << 1;
                s.dy = 2'd2 - (eb << 1);
            end
            4'd3: begin
                s.dx = 2'd1 + eb - ea;
                s.dy = 2'd2 - ea - eb;
            end
            4'd4: begin
                s.dx = 2'd1;
                s.dy = 2'd1;
                s.b  = ~b;
            end
            4'd5: begin
                s.dx = ea - eb + 2'd1;
                s.dy = ea + eb;
                s.b  = ~b;
            end
            4'd6: begin
                s.dx = 2'd2 - (eb << 1);
                s.dy = eb << 1;
                s.a  = ~a;
            end
            4'd7: begin
                s.dx = 2'd2 - ea - eb;
                s.dy = 2'd1 + eb - ea;
                s.a  = ~a;
            end
            default: begin
                s.dx = 2'd2 - (ea << 1);
                s.dy = 2'd2 - (ea << 1);
            end
        endcase
        return s;
    endfunction

endpackage

// File: design/pcxy_front.sv
// Front end: configuration registers, input transfer and range classification.
module pcxy_front #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [pcxy_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pcxy_pkg::IDX_W-1:0]      i_curve_index,
    input  logic                            i_q_full,
    output pcxy_pkg::t_push                 o_push
);

    logic [2:0]                  r_levels;
    logic                        r_orient_a;
    logic                        r_orient_b;
    logic [pcxy_pkg::LV_W-1:0]   lv;
    logic [31:0]                 span;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels   <= 3'd2;
            r_orient_a <= 1'b0;
            r_orient_b <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pcxy_pkg::CFG_LEVELS:   r_levels   <= i_cfg_data;
                pcxy_pkg::CFG_ORIENT_A: r_orient_a <= i_cfg_data[0];
                pcxy_pkg::CFG_ORIENT_B: r_orient_b <= i_cfg_data[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Clamp depth and look up 9^depth
    always_comb begin
        lv = ({1'b0, r_levels} > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : {1'b0, r_levels};
        span = pcxy_pkg::POW9[0];
        for (int k = 1; k <= 8; k++) begin
            if (lv == 4'(k)) span = pcxy_pkg::POW9[k];
        end
    end

    assign o_ready         = !i_q_full;
    assign o_push.valid    = i_valid && !i_q_full;
    assign o_push.item.idx = i_curve_index;
    assign o_push.item.lv  = lv;
    assign o_push.item.a   = r_orient_a;
    assign o_push.item.b   = r_orient_b;
    assign o_push.item.oor = ({16'b0, i_curve_index} >= span);

endmodule

// File: design/pcxy_queue.sv
// Two-entry queue between front and back end.
module pcxy_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pcxy_pkg::t_push i_push,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pcxy_pkg::t_item o_item
);

    pcxy_pkg::t_item r_mem [pcxy_pkg::QDEPTH];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            pop;

    assign o_full  = (r_count == 2'(pcxy_pkg::QDEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) r_wr_ptr <= ~r_wr_ptr;
            if (pop)          r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push.valid) - 2'(pop);
        end
    end

endmodule

// File: design/pcxy_back.sv
// Back end: one pipeline stage per level, each peeling one base-9 digit.
module pcxy_back #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  pcxy_pkg::t_item                   i_q_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pcxy_pkg::COORD_W-1:0]      o_coord_x,
    output logic [pcxy_pkg::COORD_W-1:0]      o_coord_y,
    output logic                              o_out_of_range
);

    localparam int S  = MAX_LEVELS;
    localparam int CW = $clog2(pcxy_pkg::POW3[MAX_LEVELS]);

    logic                          r_vld [S];
    logic [pcxy_pkg::IDX_W-1:0]    r_rem [S];
    logic [CW-1:0]                 r_x   [S];
    logic [CW-1:0]                 r_y   [S];
    logic                          r_a   [S];
    logic                          r_b   [S];
    logic [pcxy_pkg::LV_W-1:0]     r_lv  [S];
    logic                          r_oor [S];

    logic                          en;
    logic [CW+7:0]                 ext_x;
    logic [CW+7:0]                 ext_y;

    // Whole pipe advances when the last stage is empty or being taken
    assign en    = !r_vld[S-1] || i_ready;
    assign o_pop = en;

    genvar j;
    generate
        for (j = 0; j < S; j++) begin : g_stage
            localparam int L = S - 1 - j;

            logic                       s_vld;
            logic [pcxy_pkg::IDX_W-1:0] s_rem;
            logic [CW-1:0]              s_x;
            logic [CW-1:0]              s_y;
            logic                       s_a;
            logic                       s_b;
            logic [pcxy_pkg::LV_W-1:0]  s_lv;
            logic                       s_oor;
            logic [3:0]                 digit;
            pcxy_pkg::t_sub             sub;
            logic                       act;
            logic [CW-1:0]              off_x;
            logic [CW-1:0]              off_y;
            logic [31:0]                rem_next;

            if (j == 0) begin : g_head
                assign s_vld = i_q_valid;
                assign s_rem = i_q_item.idx;
                assign s_x   = '0;
                assign s_y   = '0;
                assign s_a   = i_q_item.a;
                assign s_b   = i_q_item.b;
                assign s_lv  = i_q_item.lv;
                assign s_oor = i_q_item.oor;
            end else begin : g_chain
                assign s_vld = r_vld[j-1];
                assign s_rem = r_rem[j-1];
                assign s_x   = r_x[j-1];
                assign s_y   = r_y[j-1];
                assign s_a   = r_a[j-1];
                assign s_b   = r_b[j-1];
                assign s_lv  = r_lv[j-1];
                assign s_oor = r_oor[j-1];
            end

            // Digit at this level: how many multiples of 9^L fit
            always_comb begin
                digit = 4'd0;
                for (int m = 1; m <= 8; m++) begin
                    if ({16'b0, s_rem} >= 32'(m) * pcxy_pkg::POW9[L]) digit = digit + 4'd1;
                end
            end

            assign act      = !s_oor && (4'(L) < s_lv);
            assign sub      = pcxy_pkg::subblock(digit, s_a, s_b);
            assign rem_next = {16'b0, s_rem} - {28'b0, digit} * pcxy_pkg::POW9[L];
            assign off_x    = (sub.dx == 2'd2) ? CW'(2 * pcxy_pkg::POW3[L]) :
                              (sub.dx == 2'd1) ? CW'(pcxy_pkg::POW3[L]) : '0;
            assign off_y    = (sub.dy == 2'd2) ? CW'(2 * pcxy_pkg::POW3[L]) :
                              (sub.dy == 2'd1) ? CW'(pcxy_pkg::POW3[L]) : '0;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (en) begin
                    r_vld[j] <= s_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_lv[j]  <= s_lv;
                    r_oor[j] <= s_oor;
                    if (act) begin
                        r_rem[j] <= rem_next[pcxy_pkg::IDX_W-1:0];
                        r_x[j]   <= s_x + off_x;
                        r_y[j]   <= s_y + off_y;
                        r_a[j]   <= sub.a;
                        r_b[j]   <= sub.b;
                    end else begin
                        r_rem[j] <= s_rem;
                        r_x[j]   <= s_x;
                        r_y[j]   <= s_y;
                        r_a[j]   <= s_a;
                        r_b[j]   <= s_b;
                    end
                end
            end
        end
    endgenerate

    assign ext_x          = {8'b0, r_x[S-1]};
    assign ext_y          = {8'b0, r_y[S-1]};
    assign o_valid        = r_vld[S-1];
    assign o_out_of_range = r_oor[S-1];
    assign o_coord_x      = r_oor[S-1] ? '0 : ext_x[pcxy_pkg::COORD_W-1:0];
    assign o_coord_y      = r_oor[S-1] ? '0 : ext_y[pcxy_pkg::COORD_W-1:0];

endmodule

// File: design/peano_curve_index_to_xy.sv
// Top level of the Peano curve index-to-point mapper.
//
// Usage: present a curve index on i_curve_index with i_valid; it transfers
// when o_ready is high too. One result (o_coord_x, o_coord_y, o_out_of_range)
// follows per index, in order, on o_valid/i_ready.
// Configuration: registers written on i_cfg_valid with i_cfg_index
// (0 levels, 1 start orientation a, 2 start orientation b) and i_cfg_data;
// o_cfg_ready is always high. Write only while the block holds no items.
// Path: the queue entry written at the input transfer feeds the first stage,
// and each of the MAX_LEVELS stages takes one base-9 digit off the index,
// the last one driving the outputs.
// Throughput: one index per cycle while the output is not stalled, set by
// the per-level stage pipeline.
// Indices at or above 9^min(levels, MAX_LEVELS) flag out of range; zero point.
// Reset: levels = 2, orientations 0, queue and pipeline emptied.
// Receiver stall: the pipeline holds, the queue fills, and o_ready drops
// once both queue entries are occupied.
module peano_curve_index_to_xy #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [pcxy_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pcxy_pkg::IDX_W-1:0]      i_curve_index,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pcxy_pkg::COORD_W-1:0]    o_coord_x,
    output logic [pcxy_pkg::COORD_W-1:0]    o_coord_y,
    output logic                            o_out_of_range
);

    pcxy_pkg::t_push push;
    pcxy_pkg::t_item q_item;
    logic            q_full;
    logic            q_valid;
    logic            pop;

    // Classify each index against the current depth and snapshot the config
    pcxy_front #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_curve_index (i_curve_index),
        .i_q_full      (q_full),
        .o_push        (push)
    );

    // Decouple input transfers from output stalls
    pcxy_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Walk the levels from the top digit down, one stage each
    pcxy_back #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_coord_x      (o_coord_x),
        .o_coord_y      (o_coord_y),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// File: dv/pcxy_point_checker.sv
// Checker for the Peano index-to-point mapper: predicts each point and compares transfers.
`timescale 1ns / 100ps

module pcxy_point_checker #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [1:0]                             i_cfg_index,
    input  logic [pcxy_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic [pcxy_pkg::IDX_W-1:0]             i_index,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic [pcxy_pkg::COORD_W-1:0]           i_x,
    input  logic [pcxy_pkg::COORD_W-1:0]           i_y,
    input  logic                                   i_oor,
    output int                                     o_errors,
    output int                                     o_pending
);

    // Sub-block positions along the serpentine, one per base-9 digit
    typedef enum int {
        SB_FIRST   = 0,
        SB_SECOND  = 1,
        SB_THIRD   = 2,
        SB_FOURTH  = 3,
        SB_CENTRE  = 4,
        SB_SIXTH   = 5,
        SB_SEVENTH = 6,
        SB_EIGHTH  = 7,
        SB_LAST    = 8
    } t_sub_pos;

    typedef struct packed {
        logic [pcxy_pkg::COORD_W-1:0] x;
        logic [pcxy_pkg::COORD_W-1:0] y;
        logic                         oor;
    } t_point;

    t_point                     points_due[$];
    logic [pcxy_pkg::CFG_W-1:0] levels_reg = 3'd2;
    logic                       orient_a   = 1'b0;
    logic                       orient_b   = 1'b0;
    int                         n_errors   = 0;
    int                         n_reported = 0;

    function automatic t_point locate_point(input logic [pcxy_pkg::IDX_W-1:0] idx,
                                            input logic [pcxy_pkg::CFG_W-1:0] lv_reg,
                                            input logic a0, input logic b0);
        t_point   p;
        int       depth;
        int       span;
        int       unit;
        int       k;
        int       ia;
        int       ib;
        int       dx;
        int       dy;
        int       x;
        int       y;
        t_sub_pos pos;
        depth = (lv_reg > MAX_LEVELS) ? MAX_LEVELS : int'(lv_reg);
        span  = 1;
        unit  = 1;
        for (k = 0; k < depth; k++) begin
            span *= 9;
            unit *= 3;
        end
        p = '0;
        if (int'(idx) >= span) begin
            p.oor = 1'b1;
            return p;
        end
        ia = a0;
        ib = b0;
        x  = 0;
        y  = 0;
        for (k = depth; k > 0; k--) begin
            span /= 9;
            unit /= 3;
            pos = t_sub_pos'((int'(idx) / span) % 9);
            unique case (pos)
                SB_FIRST: begin
                    dx = 2 * ia;
                    dy = 2 * ia;
                end
                SB_SECOND: begin
                    dx = ia + ib;
                    dy = ia - ib + 1;
                    ia = 1 - ia;
                    ib = 1 - ib;
                end
                SB_THIRD: begin
                    dx = 2 * ib;
                    dy = 2 - 2 * ib;
                end
                SB_FOURTH: begin
                    dx = 1 + ib - ia;
                    dy = 2 - ia - ib;
                end
                SB_CENTRE: begin
                    dx = 1;
                    dy = 1;
                    ib = 1 - ib;
                end
                SB_SIXTH: begin
                    dx = ia - ib + 1;
                    dy = ia + ib;
                    ib = 1 - ib;
                end
                SB_SEVENTH: begin
                    dx = 2 - 2 * ib;
                    dy = 2 * ib;
                    ia = 1 - ia;
                end
                SB_EIGHTH: begin
                    dx = 2 - ia - ib;
                    dy = 1 + ib - ia;
                    ia = 1 - ia;
                end
                default: begin
                    dx = 2 - 2 * ia;
                    dy = 2 - 2 * ia;
                end
            endcase
            x += dx * unit;
            y += dy * unit;
        end
        p.x = pcxy_pkg::COORD_W'(x);
        p.y = pcxy_pkg::COORD_W'(y);
        return p;
    endfunction

    // Count every mismatch, print only the first few
    task automatic report(input string what, input int got, input int want);
        n_errors++;
        if (n_reported < 20) begin
            n_reported++;
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_point want;
        if (!i_rst_n) begin
            levels_reg = 3'd2;
            orient_a   = 1'b0;
            orient_b   = 1'b0;
            points_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (points_due.size() == 0) begin
                    report("result with nothing due", int'(i_x), -1);
                end else begin
                    want = points_due.pop_front();
                    if (i_x !== want.x)
                        report("coord_x", int'(i_x), int'(want.x));
                    if (i_y !== want.y)
                        report("coord_y", int'(i_y), int'(want.y));
                    if (i_oor !== want.oor)
                        report("out_of_range", int'(i_oor), int'(want.oor));
                end
            end
            if (i_in_valid && i_in_ready)
                points_due.push_back(locate_point(i_index, levels_reg, orient_a, orient_b));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pcxy_pkg::CFG_LEVELS:   levels_reg = i_cfg_data;
                    pcxy_pkg::CFG_ORIENT_A: orient_a   = i_cfg_data[0];
                    pcxy_pkg::CFG_ORIENT_B: orient_b   = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_errors  <= n_errors;
        o_pending <= points_due.size();
    end

endmodule

// File: dv/tb_peano_curve_index_to_xy.sv
// Testbench top for the Peano index-to-point mapper: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_peano_curve_index_to_xy;

    localparam int LEVEL_CAP     = 5;
    // Input transfer to result: the queue plus one stage per level, with margin
    localparam int SETTLE_CYCLES = 2 * (LEVEL_CAP + 1);
    // Long receiver hold-off, well beyond queue plus pipeline depth
    localparam int HOLD_CYCLES   = 48;
    localparam int HOLD_AFTER    = 150;
    localparam int RUN_BATCHES   = 10;
    // Index on the configuration port that selects no register
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [1:0]                     i_cfg_index;
    logic [pcxy_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_valid;
    logic                           o_ready;
    logic [pcxy_pkg::IDX_W-1:0]     i_curve_index;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [pcxy_pkg::COORD_W-1:0]   o_coord_x;
    logic [pcxy_pkg::COORD_W-1:0]   o_coord_y;
    logic                           o_out_of_range;

    int                             n_errors;
    int                             n_pending;
    // Level setting in force, so that indices can be aimed at the live grid
    logic [pcxy_pkg::CFG_W-1:0]     cur_levels = 3'd2;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    peano_curve_index_to_xy #(
        .MAX_LEVELS(LEVEL_CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_curve_index  (i_curve_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_coord_x      (o_coord_x),
        .o_coord_y      (o_coord_y),
        .o_out_of_range (o_out_of_range)
    );

    pcxy_point_checker #(
        .MAX_LEVELS(LEVEL_CAP)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_index     (i_curve_index),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_x         (o_coord_x),
        .i_y         (o_coord_y),
        .i_oor       (o_out_of_range),
        .o_errors    (n_errors),
        .o_pending   (n_pending)
    );

    // Gap length: mostly none, often short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Aim most indices inside the live grid, some at its edge, the rest anywhere
    function automatic logic [pcxy_pkg::IDX_W-1:0] pick_index(
        input logic [pcxy_pkg::CFG_W-1:0] lv_reg);
        int depth;
        int span;
        int k;
        int r;
        depth = (lv_reg > LEVEL_CAP) ? LEVEL_CAP : int'(lv_reg);
        span  = 1;
        for (k = 0; k < depth; k++)
            span *= 9;
        r = $urandom_range(0, 99);
        if (r < 78)
            return pcxy_pkg::IDX_W'($urandom_range(0, span - 1));
        if (r < 88)
            return pcxy_pkg::IDX_W'(span - 1 + $urandom_range(0, 2));
        return pcxy_pkg::IDX_W'($urandom);
    endfunction

    // Offer one index and hold it until it transfers; valid is left high
    task automatic push_index(input logic [pcxy_pkg::IDX_W-1:0] idx);
        i_valid       <= 1'b1;
        i_curve_index <= idx;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [pcxy_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    // Write all three registers; optionally poke the unused index first, which must
    // change nothing. Orientation writes carry random upper bits.
    task automatic config_set(input logic [pcxy_pkg::CFG_W-1:0] lv, input logic a,
                              input logic b, input bit poke_unused);
        logic [pcxy_pkg::CFG_W-1:0] data;
        if (poke_unused)
            write_reg(CFG_UNUSED, pcxy_pkg::CFG_W'($urandom));
        write_reg(pcxy_pkg::CFG_LEVELS, lv);
        data    = pcxy_pkg::CFG_W'($urandom);
        data[0] = a;
        write_reg(pcxy_pkg::CFG_ORIENT_A, data);
        data    = pcxy_pkg::CFG_W'($urandom);
        data[0] = b;
        write_reg(pcxy_pkg::CFG_ORIENT_B, data);
        i_cfg_valid <= 1'b0;
        cur_levels   = lv;
    endtask

    // Drop valid and hold off until every result has transferred, then let the
    // pipeline settle so that the next register write lands on an idle block
    task automatic wait_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (n_pending != 0);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    // Sender: directed cases first, then randomised batches under random settings
    initial begin : source
        int                         k;
        int                         batch;
        int                         count;
        int                         gap;
        int                         r;
        bit                         burst;
        logic [pcxy_pkg::CFG_W-1:0] lv;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = pcxy_pkg::CFG_LEVELS;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_curve_index = '0;
        repeat (4)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: two levels, both orientations clear; straddle the grid end
        push_index(pcxy_pkg::IDX_W'(80));
        push_index(pcxy_pkg::IDX_W'(81));
        wait_drained();

        // One level: walk every sub-block once, then step just off the grid and
        // hit the widest index
        config_set(3'd1, 1'b0, 1'b0, 1'b1);
        for (k = 0; k < 9; k++)
            push_index(pcxy_pkg::IDX_W'(k));
        push_index(pcxy_pkg::IDX_W'(9));
        push_index('1);
        wait_drained();

        // Full depth with both orientations set: first and last points, the first
        // index off the grid, the top of the index field and its top bit alone
        config_set(3'd5, 1'b1, 1'b1, 1'b0);
        push_index(pcxy_pkg::IDX_W'(0));
        push_index(pcxy_pkg::IDX_W'(59048));
        push_index(pcxy_pkg::IDX_W'(59049));
        push_index('1);
        push_index(pcxy_pkg::IDX_W'(16'h8000));
        wait_drained();

        // Zero levels: a single-point grid
        config_set(3'd0, 1'b0, 1'b1, 1'b0);
        push_index(pcxy_pkg::IDX_W'(0));
        push_index(pcxy_pkg::IDX_W'(1));
        wait_drained();

        // Level setting above the cap must clamp to full depth
        config_set(3'd7, 1'b1, 1'b0, 1'b0);
        push_index(pcxy_pkg::IDX_W'(59048));
        push_index(pcxy_pkg::IDX_W'(59049));
        wait_drained();

        config_set(3'd3, 1'b0, 1'b1, 1'b1);
        push_index(pcxy_pkg::IDX_W'(728));
        push_index(pcxy_pkg::IDX_W'(729));
        wait_drained();

        // Random batches; the first two force the deepest grid and a single level
        for (batch = 0; batch < RUN_BATCHES; batch++) begin
            if (batch == 0) begin
                lv = 3'd5;
            end else if (batch == 1) begin
                lv = 3'd1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    lv = 3'd0;
                else if (r < 20)
                    lv = pcxy_pkg::CFG_W'($urandom_range(6, 7));
                else
                    lv = pcxy_pkg::CFG_W'($urandom_range(1, 5));
            end
            config_set(lv, 1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
            burst = ($urandom_range(0, 3) == 0);
            count = $urandom_range(55, 85);
            for (k = 0; k < count; k++) begin
                push_index(pick_index(cur_levels));
                gap = burst ? 0 : pick_gap();
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap)
                        @(posedge i_clk);
                end
            end
            wait_drained();
        end

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls in stretches, with steady spells of no stalls, and one
    // long hold-off part-way in, started while the sender is offering, so that the
    // queue fills and input transfers stop
    initial begin : sink
        int n_taken;
        int stall_left;
        int mode_left;
        bit steady;
        bit held;
        n_taken    = 0;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        held       = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                n_taken++;
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(30, 120);
            end else begin
                mode_left--;
            end
            if (!held && n_taken >= HOLD_AFTER && i_valid) begin
                held     = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge i_clk);
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready   <= 1'b1;
                stall_left = steady ? 0 : pick_gap();
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
design/pcxy_pkg.sv
design/pcxy_front.sv
design/pcxy_queue.sv
design/pcxy_back.sv
design/peano_curve_index_to_xy.sv
dv/pcxy_point_checker.sv
dv/tb_peano_curve_index_to_xy.sv
